// ----- hdl/afsk_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the sine lookup for the AFSK tone generator.
// Used by every module of the block; depends on nothing else.
package afsk_pkg;

  localparam int LUT_DEPTH   = 256;
  localparam int PHASE_STEPS = 10000;

  localparam int INC_W      = 16;
  localparam int LEVEL_W    = 8;
  localparam int POS_OUT_W  = 8;
  localparam int CFG_IDX_W  = 1;

  // The table size is a power of two, so the position wraps by truncation.
  localparam int POS_W    = $clog2(LUT_DEPTH);
  localparam int SUM_MAX  = (PHASE_STEPS - 1) + (2 ** INC_W - 1);
  localparam int SUM_W    = $clog2(SUM_MAX + 1);
  localparam int RES_W    = $clog2(PHASE_STEPS);
  localparam int QUOT_MAX = SUM_MAX / PHASE_STEPS;
  localparam int WHOLE_W  = $clog2(QUOT_MAX + 1);

  localparam int QUARTER_LEN = LUT_DEPTH / 4 + 1;
  localparam int AMP_W       = LEVEL_W - 1;
  localparam int QIDX_W      = POS_W - 1;

  localparam logic [INC_W-1:0]   MARK_INC_RST  = INC_W'(3146);
  localparam logic [INC_W-1:0]   SPACE_INC_RST = INC_W'(5767);
  localparam logic [LEVEL_W-1:0] MID_LEVEL     = LEVEL_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARK_INC  = 1'b0,
    REG_SPACE_INC = 1'b1
  } cfg_reg_t;

  // Handshake and payload from the phase stage to the lookup stage.
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] position;
  } s1_t;

  // First quarter of the offset sine amplitude, including the peak entry.
  localparam logic [AMP_W-1:0] AMP_TABLE [0:QUARTER_LEN-1] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd13,  7'd16,  7'd19,  7'd22,  7'd25,  7'd28,
    7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,  7'd49,  7'd52,  7'd54,  7'd57,
    7'd60,  7'd63,  7'd65,  7'd68,  7'd71,  7'd73,  7'd76,  7'd78,  7'd80,  7'd83,
    7'd85,  7'd87,  7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
    7'd105, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd115, 7'd116, 7'd117, 7'd118,
    7'd119, 7'd121, 7'd121, 7'd122, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126, 7'd126,
    7'd126, 7'd127, 7'd127, 7'd127, 7'd127
  };

  // Full-period sine sample, built from the quarter table by symmetry.
  function automatic logic [LEVEL_W-1:0] sine_rom(input logic [POS_W-1:0] pos);
    logic [QIDX_W-1:0] k;
    logic [QIDX_W-1:0] kf;
    logic [AMP_W-1:0]  amp;
    k  = pos[QIDX_W-1:0];
    // Past the peak the second quarter mirrors the first.
    kf = (k > QIDX_W'(LUT_DEPTH / 4)) ? QIDX_W'(-k) : k;
    amp = AMP_TABLE[kf];
    if (pos[POS_W-1]) begin
      return MID_LEVEL - {1'b0, amp};
    end else begin
      return MID_LEVEL + {1'b0, amp};
    end
  endfunction

endpackage

// ----- hdl/afsk_dds_tone_generator.sv -----
`timescale 1ns / 1ps
// AFSK tone generator by direct digital synthesis, top level.
// Depends on afsk_pkg, afsk_phase_acc and afsk_sine_out.
//
// Each transfer on the input channel is one sample tick carrying the tone
// bit (1 mark, 0 space). The matching increment is added to a shared phase
// residual, whole steps advance the table position, and one result carries
// the sine sample at the new position together with that position.
// The cfg port writes the mark increment (index 0) or the space increment
// (index 1); writes to other indexes are ignored. Write it only while idle.
// Throughput is one tick per cycle while in_stall is low: the residual add,
// the small quotient compare and the position update are all in the phase stage.
// A tick's new position is registered in the phase stage; the sine lookup
// then fills the output register from that position.
// Reset clears the residual and position to zero, restores the default
// increments and empties both stages. When the receiver stalls, the result
// holds; a tick is still taken into the phase stage if that stage is empty,
// and once both stages are full in_stall stays high until the output is taken.
module afsk_dds_tone_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [afsk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afsk_pkg::INC_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_tone_bit,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [afsk_pkg::LEVEL_W-1:0]   out_sample_level,
  output logic [afsk_pkg::POS_OUT_W-1:0] out_table_position
);
  import afsk_pkg::*;

  s1_t  s1;
  logic s2_ready;

  afsk_phase_acc u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_tone_bit(in_tone_bit),
    .s2_ready   (s2_ready),
    .s1         (s1)
  );

  afsk_sine_out u_sine (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1                (s1),
    .s2_ready          (s2_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_level  (out_sample_level),
    .out_table_position(out_table_position)
  );

`ifndef NO_ASSERTIONS
  // The input side only stalls when both stages are full and the output waits.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline had room");

  // The level shown always belongs to the position shown.
  a_level_matches_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_level == sine_rom(POS_W'(out_table_position))))
    else $error("sample level does not match table position");

  // A result appears only after the phase stage held a tick.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1.valid))
    else $error("result appeared without a tick in the phase stage");
`endif

endmodule

// ----- hdl/afsk_phase_acc.sv -----
`timescale 1ns / 1ps
// Phase stage: increment registers, fractional residual and table position.
// Depends on afsk_pkg.
module afsk_phase_acc (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [afsk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afsk_pkg::INC_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_tone_bit,
  input  logic                           s2_ready,
  output afsk_pkg::s1_t                  s1
);
  import afsk_pkg::*;

  logic [INC_W-1:0]   mark_inc_r;
  logic [INC_W-1:0]   space_inc_r;
  logic [RES_W-1:0]   residual_r;
  logic [RES_W-1:0]   residual_nxt;
  logic [POS_W-1:0]   position_r;
  logic [POS_W-1:0]   position_nxt;
  logic               valid_r;
  logic               load;
  logic               accept;
  logic [INC_W-1:0]   step;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   rem;
  logic [WHOLE_W-1:0] whole;

  assign load     = !valid_r || s2_ready;
  assign in_stall = !load;
  assign accept   = in_valid && load;

  assign step = in_tone_bit ? mark_inc_r : space_inc_r;
  assign sum  = SUM_W'(residual_r) + SUM_W'(step);

  // The quotient is small, so each candidate multiple is compared in parallel.
  always_comb begin
    whole = '0;
    rem   = sum;
    for (int k = 1; k <= QUOT_MAX; k++) begin
      if (sum >= SUM_W'(k * PHASE_STEPS)) begin
        whole = WHOLE_W'(k);
        rem   = sum - SUM_W'(k * PHASE_STEPS);
      end
    end
    residual_nxt = RES_W'(rem);
    position_nxt = position_r + POS_W'(whole);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_inc_r  <= MARK_INC_RST;
      space_inc_r <= SPACE_INC_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_MARK_INC:  mark_inc_r  <= cfg_wdata;
        REG_SPACE_INC: space_inc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      residual_r <= '0;
      position_r <= '0;
      valid_r    <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= in_valid;
      end
      if (accept) begin
        residual_r <= residual_nxt;
        position_r <= position_nxt;
      end
    end
  end

  // The position only moves on a transfer in, so it holds while stage two waits.
  assign s1.valid    = valid_r;
  assign s1.position = position_r;

endmodule

// ----- hdl/afsk_sine_out.sv -----
`timescale 1ns / 1ps
// Lookup stage: sine table read into the result register.
// Depends on afsk_pkg.
module afsk_sine_out (
  input  logic                           clk,
  input  logic                           rst_n,
  input  afsk_pkg::s1_t                  s1,
  output logic                           s2_ready,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [afsk_pkg::LEVEL_W-1:0]   out_sample_level,
  output logic [afsk_pkg::POS_OUT_W-1:0] out_table_position
);
  import afsk_pkg::*;

  logic                 valid_r;
  logic [LEVEL_W-1:0]   level_r;
  logic [POS_OUT_W-1:0] pos_r;

  assign s2_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s2_ready) begin
      valid_r <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1.valid) begin
      level_r <= sine_rom(s1.position);
      pos_r   <= POS_OUT_W'(s1.position);
    end
  end

  assign out_valid          = valid_r;
  assign out_sample_level   = level_r;
  assign out_table_position = pos_r;

endmodule
